// ===== src/rafp_pkg.sv =====
// Shared types and constants for the radio API frame parser.
// No dependencies; used by rafp_parser and radio_api_frame_parser.
package rafp_pkg;

    localparam int unsigned SENDER_ADDRESS_BYTES = 8;
    localparam int unsigned SHORT_ADDRESS_BYTES  = 2;

    localparam logic [7:0] TYPE_RECEIVE   = 8'h90;
    localparam logic [7:0] TYPE_TX_STATUS = 8'h89;
    localparam logic [7:0] SUM_GOOD       = 8'hFF;

    // type and options bytes plus both addresses
    localparam logic [15:0] OVERHEAD =
        16'(2 + SENDER_ADDRESS_BYTES + SHORT_ADDRESS_BYTES);
    localparam logic [15:0] SENDER_LAST = 16'(SENDER_ADDRESS_BYTES - 1);
    localparam logic [15:0] SHORT_LAST  = 16'(SHORT_ADDRESS_BYTES - 1);

    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_RX_END    = 2'd1;
    localparam logic [1:0] KIND_TX_END    = 2'd2;
    localparam logic [1:0] KIND_BAD_TYPE  = 2'd3;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic [63:0] sender_address;
        logic [15:0] short_address;
        logic [7:0]  receive_options;
        logic [7:0]  frame_identifier;
        logic [7:0]  delivery_code;
        logic        checksum_ok;
        logic [7:0]  type_byte;
        logic [15:0] payload_count;
    } result_t;

endpackage

// ===== src/rafp_parser.sv =====
// Byte-at-a-time frame state machine: updates parse state on each transfer
// and forms the result (if any) combinationally. Depends on rafp_pkg.
module rafp_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           rx_byte,
    output logic                 emit,
    output rafp_pkg::result_t    result
);

    localparam logic [3:0] PH_DELIM    = 4'd0;
    localparam logic [3:0] PH_LEN_HI   = 4'd1;
    localparam logic [3:0] PH_LEN_LO   = 4'd2;
    localparam logic [3:0] PH_TYPE     = 4'd3;
    localparam logic [3:0] PH_SENDER   = 4'd4;
    localparam logic [3:0] PH_SHORT    = 4'd5;
    localparam logic [3:0] PH_OPTIONS  = 4'd6;
    localparam logic [3:0] PH_PAYLOAD  = 4'd7;
    localparam logic [3:0] PH_RX_SUM   = 4'd8;
    localparam logic [3:0] PH_FRAME_ID = 4'd9;
    localparam logic [3:0] PH_STATUS   = 4'd10;
    localparam logic [3:0] PH_TX_SUM   = 4'd11;

    logic [3:0]  phase_reg,   phase_next;
    logic [15:0] count_reg,   count_next;
    logic [7:0]  len_hi_reg,  len_hi_next;
    logic [15:0] plen_reg,    plen_next;
    logic [7:0]  kind_reg,    kind_next;
    logic [63:0] sender_reg,  sender_next;
    logic [15:0] short_reg,   short_next;
    logic [7:0]  options_reg, options_next;
    logic [7:0]  id_reg,      id_next;
    logic [7:0]  status_reg,  status_next;
    logic [7:0]  sum_reg,     sum_next;

    logic [15:0] len_full;
    logic [7:0]  sum_with_byte;
    logic        sum_good;

    assign len_full      = {len_hi_reg, rx_byte};
    assign sum_with_byte = sum_reg + rx_byte;
    assign sum_good      = (sum_with_byte == rafp_pkg::SUM_GOOD);

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        len_hi_next  = len_hi_reg;
        plen_next    = plen_reg;
        kind_next    = kind_reg;
        sender_next  = sender_reg;
        short_next   = short_reg;
        options_next = options_reg;
        id_next      = id_reg;
        status_next  = status_reg;
        sum_next     = (phase_reg >= PH_TYPE) ? sum_with_byte : sum_reg;
        emit         = 1'b0;
        result       = '0;

        unique case (phase_reg)
            PH_DELIM:
            begin
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_hi_next = rx_byte;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                plen_next  = (len_full > rafp_pkg::OVERHEAD) ?
                             len_full - rafp_pkg::OVERHEAD : 16'd0;
                phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                sum_next     = rx_byte;
                kind_next    = rx_byte;
                sender_next  = '0;
                short_next   = '0;
                options_next = '0;
                id_next      = '0;
                status_next  = '0;
                count_next   = '0;
                if (rx_byte == rafp_pkg::TYPE_RECEIVE)
                begin
                    phase_next = PH_SENDER;
                end
                else if (rx_byte == rafp_pkg::TYPE_TX_STATUS)
                begin
                    phase_next = PH_FRAME_ID;
                end
                else
                begin
                    emit               = 1'b1;
                    result.result_kind = rafp_pkg::KIND_BAD_TYPE;
                    result.type_byte   = rx_byte;
                    phase_next         = PH_DELIM;
                end
            end
            PH_SENDER:
            begin
                sender_next = {sender_reg[55:0], rx_byte};
                if (count_reg == rafp_pkg::SENDER_LAST)
                begin
                    count_next = '0;
                    phase_next = PH_SHORT;
                end
                else
                begin
                    count_next = count_reg + 16'd1;
                end
            end
            PH_SHORT:
            begin
                short_next = {short_reg[7:0], rx_byte};
                if (count_reg == rafp_pkg::SHORT_LAST)
                begin
                    count_next = '0;
                    phase_next = PH_OPTIONS;
                end
                else
                begin
                    count_next = count_reg + 16'd1;
                end
            end
            PH_OPTIONS:
            begin
                options_next = rx_byte;
                count_next   = '0;
                phase_next   = (plen_reg != 16'd0) ? PH_PAYLOAD : PH_RX_SUM;
            end
            PH_PAYLOAD:
            begin
                emit                   = 1'b1;
                result.result_kind     = rafp_pkg::KIND_PAYLOAD;
                result.payload_byte    = rx_byte;
                result.sender_address  = sender_reg;
                result.short_address   = short_reg;
                result.receive_options = options_reg;
                result.type_byte       = kind_reg;
                result.payload_count   = plen_reg;
                if (count_reg + 16'd1 == plen_reg)
                begin
                    count_next = '0;
                    phase_next = PH_RX_SUM;
                end
                else
                begin
                    count_next = count_reg + 16'd1;
                end
            end
            PH_RX_SUM:
            begin
                emit                   = 1'b1;
                result.result_kind     = rafp_pkg::KIND_RX_END;
                result.sender_address  = sender_reg;
                result.short_address   = short_reg;
                result.receive_options = options_reg;
                result.checksum_ok     = sum_good;
                result.type_byte       = kind_reg;
                result.payload_count   = plen_reg;
                phase_next             = PH_DELIM;
            end
            PH_FRAME_ID:
            begin
                id_next    = rx_byte;
                phase_next = PH_STATUS;
            end
            PH_STATUS:
            begin
                status_next = rx_byte;
                phase_next  = PH_TX_SUM;
            end
            PH_TX_SUM:
            begin
                emit                    = 1'b1;
                result.result_kind      = rafp_pkg::KIND_TX_END;
                result.frame_identifier = id_reg;
                result.delivery_code    = status_reg;
                result.checksum_ok      = sum_good;
                result.type_byte        = kind_reg;
                phase_next              = PH_DELIM;
            end
            default:
            begin
                phase_next = PH_DELIM;
            end
        endcase

        // nothing moves without a transfer
        if (!fire)
        begin
            emit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DELIM;
            count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            len_hi_reg  <= len_hi_next;
            plen_reg    <= plen_next;
            kind_reg    <= kind_next;
            sender_reg  <= sender_next;
            short_reg   <= short_next;
            options_reg <= options_next;
            id_reg      <= id_next;
            status_reg  <= status_next;
            sum_reg     <= sum_next;
        end
    end

    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> plen_reg != 16'd0)
        else $error("payload phase entered with zero payload length");

    a_sender_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SENDER |-> count_reg <= rafp_pkg::SENDER_LAST)
        else $error("sender byte count overran");

    a_end_resync: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (phase_reg == PH_RX_SUM || phase_reg == PH_TX_SUM)
        |=> phase_reg == PH_DELIM)
        else $error("parser did not return to delimiter after checksum");

endmodule

// ===== src/radio_api_frame_parser.sv =====
// Top level of the radio API frame parser: handshakes, parser instance and
// a two-entry result queue (output register plus skid). Depends on rafp_pkg.
// A result is registered in the output register, or in the skid entry if that is full.
// Throughput: one byte per cycle; in_ready drops only when both the output
// register and the skid entry hold results not yet taken.
// Reset: rst_n async low; parser takes the next byte as the delimiter, result queue empty.
module radio_api_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic [63:0] sender_address,
    output logic [15:0] short_address,
    output logic [7:0]  receive_options,
    output logic [7:0]  frame_identifier,
    output logic [7:0]  delivery_code,
    output logic        checksum_ok,
    output logic [7:0]  type_byte,
    output logic [15:0] payload_count
);

    logic              fire;
    logic              emit;
    logic              pop;
    rafp_pkg::result_t new_result;
    rafp_pkg::result_t out_reg;
    rafp_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    assign in_ready = ~skid_valid_reg;
    assign fire     = in_valid & in_ready;
    assign pop      = out_valid_reg & out_ready;

    rafp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (rx_byte),
        .emit    (emit),
        .result  (new_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop && skid_valid_reg)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            out_valid_reg <= emit;
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if ((pop || !out_valid_reg) && emit)
        begin
            out_reg <= new_result;
        end
        else if (emit)
        begin
            skid_reg <= new_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = out_reg.result_kind;
    assign payload_byte     = out_reg.payload_byte;
    assign sender_address   = out_reg.sender_address;
    assign short_address    = out_reg.short_address;
    assign receive_options  = out_reg.receive_options;
    assign frame_identifier = out_reg.frame_identifier;
    assign delivery_code    = out_reg.delivery_code;
    assign checksum_ok      = out_reg.checksum_ok;
    assign type_byte        = out_reg.type_byte;
    assign payload_count    = out_reg.payload_count;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_no_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !emit)
        else $error("result produced while queue full");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved to output after transfer");

endmodule
